FILE: rtl/pcbl_pkg.sv
// ----------------------------------------------------------------------------
// pcbl_pkg: shared types and constants
// Widths, result kind codes and the divider request and response types for
// the polyline clip block.
// ----------------------------------------------------------------------------
package pcbl_pkg;

	localparam int DATA_W = 32;
	localparam int DIFF_W = DATA_W + 1;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef logic signed [DATA_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic        [DATA_W-1:0] umag_t;

	typedef enum logic {
		KIND_COORD = 1'b0,
		KIND_GAP   = 1'b1
	} entry_kind_t;

	// start pulse plus signed operands, quotient is |a| * |b| / |d|
	typedef struct packed {
		logic  start;
		diff_t num_a;
		diff_t mul_b;
		diff_t den_d;
	} div_req_t;

	typedef struct packed {
		logic  done;
		umag_t quo;
	} div_rsp_t;

	function automatic umag_t mag_of(input diff_t v);
		diff_t neg_v;
		neg_v = -v;
		return v[DIFF_W-1] ? neg_v[DATA_W-1:0] : v[DATA_W-1:0];
	endfunction

endpackage

FILE: rtl/pcbl_ifs.sv
// ----------------------------------------------------------------------------
// pcbl_ifs: item channels
// Valid/ready channels for input points and clipped result entries.
// ----------------------------------------------------------------------------
interface pcbl_pt_if;
	import pcbl_pkg::*;

	logic   valid;
	logic   ready;
	coord_t point_y;
	coord_t point_z;
	logic   first_point;
	logic   final_point;

	modport source (output valid, point_y, point_z, first_point, final_point, input ready);
	modport sink   (input valid, point_y, point_z, first_point, final_point, output ready);
endinterface

interface pcbl_res_if;
	import pcbl_pkg::*;

	logic   valid;
	logic   ready;
	logic   entry_kind;
	coord_t out_y;
	coord_t out_z;
	logic   run_end;

	modport source (output valid, entry_kind, out_y, out_z, run_end, input ready);
	modport sink   (input valid, entry_kind, out_y, out_z, run_end, output ready);
endinterface

FILE: rtl/pcbl_muldiv.sv
// ----------------------------------------------------------------------------
// pcbl_muldiv: bit-serial multiply-divide
// Computes floor(|a| * |b| / |d|) for |a| < |d|, one bit of b per cycle,
// msb first, keeping the running remainder below d.
// ----------------------------------------------------------------------------
module pcbl_muldiv import pcbl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} dstate_t;

	dstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	umag_t              a_q;
	umag_t              b_q;
	umag_t              d_q;
	umag_t              rem_q;
	umag_t              quo_q;
	logic               done_q;

	logic [DATA_W:0]    r2;
	logic [DATA_W:0]    t1;
	logic [DATA_W:0]    r3;
	logic [DATA_W:0]    d_ext;
	logic [DATA_W:0]    rem_w;
	logic               ge1;
	logic               ge2;
	umag_t              quo_n;

	always_comb begin
		d_ext = {1'b0, d_q};
		r2    = {rem_q, 1'b0};
		ge1   = (r2 >= d_ext);
		t1    = ge1 ? (r2 - d_ext) : r2;
		// add a when the current bit of b is set, then one more reduction
		r3    = b_q[DATA_W-1] ? (t1 + {1'b0, a_q}) : t1;
		ge2   = b_q[DATA_W-1] && (r3 >= d_ext);
		rem_w = ge2 ? (r3 - d_ext) : r3;
		quo_n = {quo_q[DATA_W-2:0], 1'b0} + {{(DATA_W-2){1'b0}}, ge1 & ge2, ge1 ^ ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			d_q     <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_RUN) && (cnt_q == '0);
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						a_q     <= mag_of(req.num_a);
						b_q     <= mag_of(req.mul_b);
						d_q     <= mag_of(req.den_d);
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= CNT_W'(DATA_W - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= rem_w[DATA_W-1:0];
					quo_q <= quo_n;
					b_q   <= {b_q[DATA_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: rtl/polyline_clip_below_level.sv
// ----------------------------------------------------------------------------
// polyline_clip_below_level: clip a cross-section polyline below a level
// Keeps the parts of the polyline at or below water_level, adds the
// interpolated crossing points and gap markers between wet runs.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  pt        in    valid / ready    point_y, point_z, first_point, final_point
//  res       out   valid / ready    entry_kind, out_y, out_z, run_end
//  cfg       in    cfg_we           cfg_data (water_level)
//
//  a point without a crossing is taken in S_IDLE, then S_EMIT sends its result entries
//  a crossing adds the operand load, 32 steps of the bit-serial
//  multiply-divide (one bit of |dy| per cycle) and the done handoff
//  the output register lets the next point in while the last entry waits
//  reset clears the previous point, the emit flag and the level to zero
// ----------------------------------------------------------------------------
module polyline_clip_below_level import pcbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DATA_W-1:0] cfg_data,
	pcbl_pt_if.sink           pt,
	pcbl_res_if.source        res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t   state_q;
	coord_t   level_q;
	coord_t   prev_y_q;
	coord_t   prev_z_q;
	logic     emitted_pt_q;
	logic     cross_q;
	logic     pt_q;
	logic     gap_q;
	coord_t   cur_y_q;
	coord_t   cur_z_q;
	coord_t   base_y_q;
	logic     neg_q;
	div_req_t div_req_q;
	div_rsp_t div_rsp;

	logic     out_valid_q;
	logic     out_kind_q;
	coord_t   out_y_q;
	coord_t   out_z_q;
	logic     out_end_q;

	logic     in_acc;
	logic     below;
	logic     crosses;
	logic     flag_mid;
	logic     gap_w;
	logic     out_free;
	coord_t   cross_y;
	logic     sel_kind;
	coord_t   sel_y;
	coord_t   sel_z;
	logic     sel_last;

	pcbl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign pt.ready = (state_q == S_IDLE);
	assign in_acc   = pt.valid && pt.ready;
	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		below    = (pt.point_z <= level_q);
		crosses  = !pt.first_point &&
			(((prev_z_q < level_q) && (level_q < pt.point_z)) ||
			 ((level_q < prev_z_q) && (pt.point_z < level_q)));
		flag_mid = crosses || below || (emitted_pt_q && !pt.first_point);
		gap_w    = !pt.first_point && flag_mid && !pt.final_point && !below;
	end

	assign cross_y = neg_q ? (base_y_q - coord_t'(div_rsp.quo))
	                       : (base_y_q + coord_t'(div_rsp.quo));

	// pending entries go out in order: crossing, point, gap
	always_comb begin
		if (cross_q) begin
			sel_kind = KIND_COORD;
			sel_y    = cross_y;
			sel_z    = level_q;
			sel_last = !(pt_q || gap_q);
		end else if (pt_q) begin
			sel_kind = KIND_COORD;
			sel_y    = cur_y_q;
			sel_z    = cur_z_q;
			sel_last = !gap_q;
		end else begin
			sel_kind = KIND_GAP;
			sel_y    = '0;
			sel_z    = '0;
			sel_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_we) begin
			level_q <= coord_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			emitted_pt_q <= 1'b0;
			cross_q      <= 1'b0;
			pt_q         <= 1'b0;
			gap_q        <= 1'b0;
			cur_y_q      <= '0;
			cur_z_q      <= '0;
			base_y_q     <= '0;
			neg_q        <= 1'b0;
			div_req_q    <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_COORD;
			out_y_q      <= '0;
			out_z_q      <= '0;
			out_end_q    <= 1'b0;
		end else begin
			div_req_q.start <= in_acc && crosses;
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cross_q      <= crosses;
						pt_q         <= below;
						gap_q        <= gap_w;
						emitted_pt_q <= flag_mid && !gap_w;
						cur_y_q      <= pt.point_y;
						cur_z_q      <= pt.point_z;
						base_y_q     <= prev_y_q;
						neg_q        <= (pt.point_y < prev_y_q);
						prev_y_q     <= pt.point_y;
						prev_z_q     <= pt.point_z;
						div_req_q.num_a <= diff_t'(level_q) - diff_t'(prev_z_q);
						div_req_q.mul_b <= diff_t'(pt.point_y) - diff_t'(prev_y_q);
						div_req_q.den_d <= diff_t'(pt.point_z) - diff_t'(prev_z_q);
						if (crosses) begin
							state_q <= S_DIV;
						end else if (below || gap_w) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_kind_q  <= sel_kind;
						out_y_q     <= sel_y;
						out_z_q     <= sel_z;
						out_end_q   <= sel_last;
						if (cross_q) begin
							cross_q <= 1'b0;
						end else if (pt_q) begin
							pt_q <= 1'b0;
						end else begin
							gap_q <= 1'b0;
						end
						if (sel_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid      = out_valid_q;
	assign res.entry_kind = out_kind_q;
	assign res.out_y      = out_y_q;
	assign res.out_z      = out_z_q;
	assign res.run_end    = out_end_q;

endmodule
